>>> src/hsv_to_rgb_converter_macros.svh
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared concurrent assertion forms, clocked on aclk and gated by aresetn.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// same-cycle implication
`define HSVRGB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HSVRGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, fixed-point constants and sector ramp functions.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    typedef logic [12:0] hue_t;
    typedef logic [8:0]  q8_t;
    typedef logic [9:0]  ramp_t;
    typedef logic [7:0]  chan_t;

    localparam hue_t  HUE_TURN   = 13'd5760;
    localparam hue_t  HUE_60     = 13'd960;
    localparam hue_t  HUE_120    = 13'd1920;
    localparam hue_t  HUE_180    = 13'd2880;
    localparam hue_t  HUE_240    = 13'd3840;
    localparam hue_t  HUE_300    = 13'd4800;
    localparam ramp_t SECTOR     = 10'd960;
    localparam q8_t   Q8_ONE     = 9'd256;

    // level * 255 * val / (2^22 * 15): shift by 22, then divide by 15
    localparam int          DEN_SHIFT   = 22;
    localparam logic [15:0] RECIP_15    = 16'd34953;
    localparam int          RECIP_SHIFT = 19;

    function automatic ramp_t red_ramp(input hue_t h);
        hue_t d;
        begin
            d = '0;
            if (h < HUE_60 || h >= HUE_300) begin
                d = hue_t'(SECTOR);
            end else if (h < HUE_120) begin
                d = HUE_120 - h;
            end else if (h < HUE_240) begin
                d = '0;
            end else begin
                d = h - HUE_240;
            end
            red_ramp = d[9:0];
        end
    endfunction

    function automatic ramp_t green_ramp(input hue_t h);
        hue_t d;
        begin
            d = '0;
            if (h >= HUE_240) begin
                d = '0;
            end else if (h >= HUE_180) begin
                d = HUE_240 - h;
            end else if (h >= HUE_60) begin
                d = hue_t'(SECTOR);
            end else begin
                d = h;
            end
            green_ramp = d[9:0];
        end
    endfunction

    function automatic ramp_t blue_ramp(input hue_t h);
        hue_t d;
        begin
            d = '0;
            if (h >= HUE_300) begin
                d = HUE_TURN - h;
            end else if (h >= HUE_240) begin
                d = hue_t'(SECTOR);
            end else if (h >= HUE_180) begin
                d = h - HUE_180;
            end else begin
                d = '0;
            end
            blue_ramp = d[9:0];
        end
    endfunction

endpackage

>>> src/hsvrgb_channel.sv
// ----------------------------------------------------------------------------
// HSV to RGB channel datapath
// Four-stage level, brightness scale and divide-by-constant pipeline.
// ----------------------------------------------------------------------------
module hsvrgb_channel (
    input  logic               aclk,
    input  logic               en,
    input  hsvrgb_pkg::ramp_t  ramp,
    input  hsvrgb_pkg::q8_t    sat,
    input  hsvrgb_pkg::q8_t    bright,
    output hsvrgb_pkg::chan_t  chan
);

    logic [17:0] level_reg, level_next;
    hsvrgb_pkg::q8_t bright_reg;
    logic [25:0] prod_reg, prod_next;
    logic [11:0] quot_reg, quot_next;
    hsvrgb_pkg::chan_t chan_reg, chan_next;

    logic [18:0] term_ramp;
    logic [18:0] term_floor;
    hsvrgb_pkg::q8_t sat_comp;
    logic [26:0] prod_full;
    logic [33:0] scaled;
    logic [27:0] recip_prod;

    always_comb begin
        sat_comp   = hsvrgb_pkg::Q8_ONE - sat;
        term_ramp  = 19'(ramp) * 19'(sat);
        term_floor = 19'(sat_comp) * 19'(hsvrgb_pkg::SECTOR);
        level_next = 18'(term_ramp + term_floor);

        prod_full  = 27'(level_reg) * 27'(bright_reg);
        prod_next  = prod_full[25:0];

        scaled     = {prod_reg, 8'b0} - {8'b0, prod_reg};
        quot_next  = scaled[hsvrgb_pkg::DEN_SHIFT +: 12];

        recip_prod = 28'(quot_reg) * 28'(hsvrgb_pkg::RECIP_15);
        chan_next  = recip_prod[hsvrgb_pkg::RECIP_SHIFT +: 8];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            level_reg  <= level_next;
            bright_reg <= bright;
            prod_reg   <= prod_next;
            quot_reg   <= quot_next;
            chan_reg   <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

>>> src/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Maps one HSV pixel per word to a packed 24-bit RGB color.
// ----------------------------------------------------------------------------
// Input channel s_*: hue in 1/16 degree (0..5759, one wrap applied above),
// saturation and brightness in Q8 (256 = 1.0, larger values clamp to 1.0).
// Output channel m_*: red in bits 23..16, green 15..8, blue 7..0.
// Each word passes five register stages from acceptance to m_valid: hue wrap
// and ramp select, level multiply, brightness multiply, scale by 255, divide
// by 15. Throughput is one word per cycle while no stall holds; the stages
// advance together whenever the output register is empty or being taken.
// When the receiver holds m_ready low with a word waiting, the whole
// pipeline holds and s_ready drops; no word is lost or repeated.
// Reset clears all stage valid bits; s_ready is high in the first cycle
// after reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [12:0] s_hue,
    input  logic [8:0]  s_saturation,
    input  logic [8:0]  s_brightness,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_color
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] vld_reg, vld_next;
    logic              advance;

    hsvrgb_pkg::hue_t  hue_w;
    hsvrgb_pkg::q8_t   sat_c, bright_c;
    hsvrgb_pkg::ramp_t ramp_r_reg, ramp_g_reg, ramp_b_reg;
    hsvrgb_pkg::q8_t   sat_reg, bright_reg;
    hsvrgb_pkg::chan_t chan_r, chan_g, chan_b;

    assign advance = !vld_reg[STAGES-1] || m_ready;
    assign s_ready = advance;

    always_comb begin
        hue_w    = (s_hue >= hsvrgb_pkg::HUE_TURN) ? s_hue - hsvrgb_pkg::HUE_TURN : s_hue;
        sat_c    = (s_saturation > hsvrgb_pkg::Q8_ONE) ? hsvrgb_pkg::Q8_ONE : s_saturation;
        bright_c = (s_brightness > hsvrgb_pkg::Q8_ONE) ? hsvrgb_pkg::Q8_ONE : s_brightness;
        vld_next = {vld_reg[STAGES-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ramp_r_reg <= hsvrgb_pkg::red_ramp(hue_w);
            ramp_g_reg <= hsvrgb_pkg::green_ramp(hue_w);
            ramp_b_reg <= hsvrgb_pkg::blue_ramp(hue_w);
            sat_reg    <= sat_c;
            bright_reg <= bright_c;
        end
    end

    hsvrgb_channel u_red (
        .aclk   (aclk),
        .en     (advance),
        .ramp   (ramp_r_reg),
        .sat    (sat_reg),
        .bright (bright_reg),
        .chan   (chan_r)
    );

    hsvrgb_channel u_green (
        .aclk   (aclk),
        .en     (advance),
        .ramp   (ramp_g_reg),
        .sat    (sat_reg),
        .bright (bright_reg),
        .chan   (chan_g)
    );

    hsvrgb_channel u_blue (
        .aclk   (aclk),
        .en     (advance),
        .ramp   (ramp_b_reg),
        .sat    (sat_reg),
        .bright (bright_reg),
        .chan   (chan_b)
    );

    assign m_valid = vld_reg[STAGES-1];
    assign m_color = {chan_r, chan_g, chan_b};

endmodule

>>> src/hsvrgb_checker.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter port checker
// Port-level checks on stall behavior, ready and pipeline drain.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_macros.svh"

module hsvrgb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [23:0] m_color
);

    logic stalled;
    logic idle;

    assign stalled = m_valid && !m_ready;
    assign idle    = !s_valid && m_ready;

    `HSVRGB_ASSERT_NEXT(a_stall_hold, stalled, m_valid && $stable(m_color), "held word changed")
    `HSVRGB_ASSERT_NOW(a_ready_free, !stalled, s_ready, "input blocked with room in pipeline")
    `HSVRGB_ASSERT_NOW(a_ready_stall, stalled, !s_ready, "input taken while output stalled")
    `HSVRGB_ASSERT_NEXT(a_drain, idle [*5], !m_valid, "word appeared without a matching input")

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_color (m_color)
);

>>> tb/hsv_to_rgb_checker.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter scoreboard
// Watches both channels of the converter. Each accepted pixel is turned
// into its expected packed color by an independent integer predictor.
// Each color taken from the output is compared in order with the oldest
// expected color. Extra colors and wrong colors add to the mismatch count.
// ----------------------------------------------------------------------------
module hsv_to_rgb_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  hsvrgb_pkg::hue_t  s_hue,
    input  hsvrgb_pkg::q8_t   s_saturation,
    input  hsvrgb_pkg::q8_t   s_brightness,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [23:0]       m_color,
    output int                mismatches,
    output int                colors_seen,
    output int                colors_owed
);

    typedef enum logic [2:0] {
        SEC_RED_YELLOW,
        SEC_YELLOW_GREEN,
        SEC_GREEN_CYAN,
        SEC_CYAN_BLUE,
        SEC_BLUE_MAGENTA,
        SEC_MAGENTA_RED
    } sector_t;

    localparam int unsigned SPAN      = int'(hsvrgb_pkg::SECTOR);
    localparam int unsigned UNITY     = int'(hsvrgb_pkg::Q8_ONE);
    localparam int unsigned TURN      = int'(hsvrgb_pkg::HUE_TURN);
    localparam longint unsigned SHADE_DIV = 64'd256 * 64'd960 * 64'd256;

    logic [23:0] expected_colors[$];

    function automatic hsvrgb_pkg::chan_t shade(input int unsigned ramp,
                                                input int unsigned sat,
                                                input int unsigned val);
        longint unsigned level;
        longint unsigned scaled;
        level  = 64'(ramp) * 64'(sat) + 64'(UNITY - sat) * 64'(SPAN);
        scaled = level * 64'd255 * 64'(val) / SHADE_DIV;
        return hsvrgb_pkg::chan_t'(scaled);
    endfunction

    function automatic logic [23:0] hsv_to_color(input hsvrgb_pkg::hue_t hue,
                                                 input hsvrgb_pkg::q8_t  sat,
                                                 input hsvrgb_pkg::q8_t  val);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned offs;
        int unsigned r_ramp;
        int unsigned g_ramp;
        int unsigned b_ramp;
        sector_t     sec;
        h = hue;
        if (h >= TURN) begin
            h = h - TURN;
        end
        s = (sat > UNITY) ? UNITY : sat;
        v = (val > UNITY) ? UNITY : val;
        sec  = sector_t'(3'(h / SPAN));
        offs = h % SPAN;
        r_ramp = 0;
        g_ramp = 0;
        b_ramp = 0;
        case (sec)
            SEC_RED_YELLOW: begin
                r_ramp = SPAN;
                g_ramp = offs;
            end
            SEC_YELLOW_GREEN: begin
                r_ramp = SPAN - offs;
                g_ramp = SPAN;
            end
            SEC_GREEN_CYAN: begin
                g_ramp = SPAN;
            end
            SEC_CYAN_BLUE: begin
                g_ramp = SPAN - offs;
                b_ramp = offs;
            end
            SEC_BLUE_MAGENTA: begin
                r_ramp = offs;
                b_ramp = SPAN;
            end
            default: begin
                r_ramp = SPAN;
                b_ramp = SPAN - offs;
            end
        endcase
        return {shade(r_ramp, s, v), shade(g_ramp, s, v), shade(b_ramp, s, v)};
    endfunction

    always @(posedge aclk) begin
        logic [23:0] want;
        if (!aresetn) begin
            expected_colors.delete();
            mismatches  = 0;
            colors_seen = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_colors.push_back(hsv_to_color(s_hue, s_saturation, s_brightness));
            end
            if (m_valid && m_ready) begin
                colors_seen++;
                if (expected_colors.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected color word: expected none, got %06h",
                             $time, m_color);
                end else begin
                    want = expected_colors.pop_front();
                    if (m_color !== want) begin
                        mismatches++;
                        $display("%0t: color mismatch: expected %06h, got %06h",
                                 $time, want, m_color);
                    end
                end
            end
        end
        colors_owed = expected_colors.size();
    end

endmodule

>>> tb/tb_hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives the converter first with directed pixels: sector boundaries, hue
// wrap, and saturation and brightness at zero, one and beyond. Then it
// drives random pixels, mostly in range, with some at the corners and some
// with fully random bits. Both sides pause at random. The receiver also
// holds off once for a long stretch, so that the pipeline fills and stalls
// its input. The scoreboard module does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;

    localparam int RANDOM_PIXELS = 1528;
    localparam int HOLD_AT       = 600;
    localparam int LONG_HOLD     = 200;
    localparam int CYCLE_LIMIT   = 200000;

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    hsvrgb_pkg::hue_t  s_hue        = '0;
    hsvrgb_pkg::q8_t   s_saturation = '0;
    hsvrgb_pkg::q8_t   s_brightness = '0;
    logic              m_ready      = 1'b0;
    logic              s_ready;
    logic              m_valid;
    logic [23:0]       m_color;

    int mismatches;
    int colors_seen;
    int colors_owed;
    int pixels_sent  = 0;
    int wild_pixels  = 0;
    int colors_taken = 0;
    int watchdog     = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    hsv_to_rgb_converter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_hue        (s_hue),
        .s_saturation (s_saturation),
        .s_brightness (s_brightness),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_color      (m_color)
    );

    hsv_to_rgb_checker color_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_hue        (s_hue),
        .s_saturation (s_saturation),
        .s_brightness (s_brightness),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_color      (m_color),
        .mismatches   (mismatches),
        .colors_seen  (colors_seen),
        .colors_owed  (colors_owed)
    );

    function automatic hsvrgb_pkg::q8_t q8_corner();
        case ($urandom_range(0, 5))
            0: return hsvrgb_pkg::q8_t'(0);
            1: return hsvrgb_pkg::q8_t'(1);
            2: return hsvrgb_pkg::q8_t'(255);
            3: return hsvrgb_pkg::Q8_ONE;
            4: return hsvrgb_pkg::q8_t'(257);
            default: return hsvrgb_pkg::q8_t'(511);
        endcase
    endfunction

    task automatic send_pixel(input hsvrgb_pkg::hue_t hue, input hsvrgb_pkg::q8_t sat,
                              input hsvrgb_pkg::q8_t val);
        int gap;
        gap = ((pixels_sent / 200) % 3 == 1) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_hue        <= hue;
        s_saturation <= sat;
        s_brightness <= val;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
        if (hue >= hsvrgb_pkg::HUE_TURN || sat > hsvrgb_pkg::Q8_ONE ||
            val > hsvrgb_pkg::Q8_ONE) begin
            wild_pixels++;
        end
        @(negedge aclk);
    endtask

    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (colors_taken == HOLD_AT) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else begin
                stall = ((colors_taken / 150) % 3 == 2) ? 0 : $urandom_range(0, 7);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            colors_taken++;
            @(negedge aclk);
        end
    end

    initial begin
        while (watchdog < CYCLE_LIMIT) begin
            @(posedge aclk);
            watchdog++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        hsvrgb_pkg::hue_t h;
        hsvrgb_pkg::q8_t  s;
        hsvrgb_pkg::q8_t  v;
        int               mode;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int k = 0; k <= 6; k++) begin
            if (k > 0) begin
                send_pixel(hsvrgb_pkg::hue_t'(hsvrgb_pkg::HUE_60 * k - 1),
                           hsvrgb_pkg::Q8_ONE, hsvrgb_pkg::Q8_ONE);
            end
            send_pixel(hsvrgb_pkg::hue_t'(hsvrgb_pkg::HUE_60 * k),
                       hsvrgb_pkg::Q8_ONE, hsvrgb_pkg::Q8_ONE);
        end
        send_pixel(13'd8191, 9'd200, 9'd180);
        send_pixel(13'd7000, 9'd511, 9'd511);
        send_pixel(13'd1234, 9'd0,   hsvrgb_pkg::Q8_ONE);
        send_pixel(13'd3000, 9'd257, 9'd128);
        send_pixel(13'd4321, 9'd128, 9'd0);
        send_pixel(13'd100,  9'd100, 9'd257);
        send_pixel(13'd5000, 9'd1,   9'd1);
        send_pixel(13'd480,  9'd255, 9'd255);

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                h = hsvrgb_pkg::hue_t'($urandom);
                s = hsvrgb_pkg::q8_t'($urandom);
                v = hsvrgb_pkg::q8_t'($urandom);
            end else if (mode == 1) begin
                h = hsvrgb_pkg::hue_t'(hsvrgb_pkg::HUE_60 * $urandom_range(1, 6)
                                       - $urandom_range(0, 1));
                s = q8_corner();
                v = q8_corner();
            end else begin
                h = hsvrgb_pkg::hue_t'($urandom_range(0, 5759));
                s = hsvrgb_pkg::q8_t'($urandom_range(0, 256));
                v = hsvrgb_pkg::q8_t'($urandom_range(0, 256));
            end
            send_pixel(h, s, v);
        end
        s_valid <= 1'b0;

        wait (colors_owed == 0);
        repeat (8) @(posedge aclk);
        $display("Converted %0d pixels, %0d with out-of-range fields; %0d colors checked",
                 pixels_sent, wild_pixels, colors_seen);
        $display("Covered all six hue sectors, hue wrap, clamping and a %0d-cycle output stall",
                 LONG_HOLD);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/hsvrgb_pkg.sv
src/hsvrgb_channel.sv
src/hsv_to_rgb_converter.sv
src/hsvrgb_checker.sv
tb/hsv_to_rgb_checker.sv
tb/tb_hsv_to_rgb_converter.sv
